@@ sv/pvp_pkg.sv @@
package pvp_pkg;

    // Field and register widths.
    localparam int CW_COORD = 24;
    localparam int CW_ROW   = 48;
    localparam int CW_ENT   = 16;
    localparam int CW_SCR   = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2 = 3'd5;

    // Register reset values.
    localparam logic [CW_COORD-1:0] RST_CAM_X = 24'sd0;
    localparam logic [CW_COORD-1:0] RST_CAM_Y = -24'sd7680;
    localparam logic [CW_COORD-1:0] RST_CAM_Z = 24'sd128000;
    localparam logic [CW_ROW-1:0]   RST_ROW0  = 48'h0000_0000_4000;
    localparam logic [CW_ROW-1:0]   RST_ROW1  = 48'h0000_4000_0000;
    localparam logic [CW_ROW-1:0]   RST_ROW2  = 48'h4000_0000_0000;

    // Internal datapath widths.
    localparam int VW    = 25;  // camera offset
    localparam int PW    = 41;  // entry times offset
    localparam int DW    = 43;  // rotated coordinate and dot product
    localparam int SQW   = 49;  // square of one offset component
    localparam int VVW   = 51;  // squared length of the offset
    localparam int NW    = 56;  // projection numerator, signed
    localparam int NMAG  = 55;  // numerator magnitude
    localparam int DZM   = 43;  // depth magnitude
    localparam int ALO   = 22;  // low part of the split dot magnitude
    localparam int AHI   = DW - ALO;
    localparam int SQ2W  = 88;  // dot squared
    localparam int QW    = 16;  // quotient bits
    localparam int CMPW  = DZM + QW; // divider compare width

    localparam logic signed [10:0] EYE_NEG = -11'sd500;

    // Transaction handed from the arithmetic front end to the divider.
    typedef struct packed {
        logic [NMAG-1:0] nabs_x;
        logic [NMAG-1:0] nabs_y;
        logic            neg_x;
        logic            neg_y;
        logic [DZM-1:0]  dzabs;
        logic            hidden;
        logic            zero_depth;
        logic            last;
    } t_div_in;

    // Finished result.
    typedef struct packed {
        logic signed [CW_SCR-1:0] screen_x;
        logic signed [CW_SCR-1:0] screen_y;
        logic                     hidden;
        logic                     zero_depth;
        logic                     last_out;
    } t_result;

endpackage

@@ sv/pvp_vtx_if.sv @@
interface pvp_vtx_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pvp_pkg::CW_COORD-1:0]   point_x;
    logic signed [pvp_pkg::CW_COORD-1:0]   point_y;
    logic signed [pvp_pkg::CW_COORD-1:0]   point_z;
    logic                                  last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

@@ sv/pvp_pix_if.sv @@
interface pvp_pix_if;
    logic                                valid;
    logic                                ready;
    logic signed [pvp_pkg::CW_SCR-1:0]   screen_x;
    logic signed [pvp_pkg::CW_SCR-1:0]   screen_y;
    logic                                hidden;
    logic                                zero_depth;
    logic                                last_out;

    modport source (output valid, screen_x, screen_y, hidden, zero_depth, last_out,
                    input ready);
    modport sink   (input valid, screen_x, screen_y, hidden, zero_depth, last_out,
                    output ready);
endinterface

@@ sv/pvp_front.sv @@
module pvp_front #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pvp_pkg::CW_COORD-1:0]  i_pt [3],
    input  logic                                 i_last,
    input  logic signed [pvp_pkg::CW_COORD-1:0]  i_cam [3],
    input  logic [pvp_pkg::CW_ROW-1:0]           i_rot [3],
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output pvp_pkg::t_div_in                     o_data
);

    localparam int NST = 6;
    localparam logic signed [12:0] HALF_X = 13'(SCREEN_WIDTH / 2);
    localparam logic signed [12:0] HALF_Y = 13'(SCREEN_HEIGHT / 2);

    logic            en;
    logic [NST-1:0]  r_vld;
    logic [NST-1:0]  r_last;

    // Stage 1: offset from the camera.
    logic signed [pvp_pkg::VW-1:0]   r1_v [3];
    // Stage 2: products.
    logic signed [pvp_pkg::PW-1:0]   r2_m [3][3];
    logic signed [pvp_pkg::PW-1:0]   r2_t [3];
    logic [pvp_pkg::SQW-1:0]         r2_s [3];
    // Stage 3: sums.
    logic signed [pvp_pkg::DW-1:0]   r3_d [3];
    logic signed [pvp_pkg::DW-1:0]   r3_dot;
    logic [pvp_pkg::VVW-1:0]         r3_vv;
    // Stage 4: numerator terms and dot-square partial products.
    logic signed [pvp_pkg::NW-1:0]   r4_px, r4_py, r4_hx, r4_hy;
    logic [2*pvp_pkg::AHI-1:0]       r4_hh;
    logic [pvp_pkg::AHI+pvp_pkg::ALO-1:0] r4_hl;
    logic [2*pvp_pkg::ALO-1:0]       r4_ll;
    logic                            r4_dotpos, r4_zd;
    logic signed [pvp_pkg::DW-1:0]   r4_dz;
    logic [pvp_pkg::VVW-1:0]         r4_vv;
    // Stage 5: numerators and dot squared.
    logic signed [pvp_pkg::NW-1:0]   r5_nx, r5_ny;
    logic [pvp_pkg::SQ2W-1:0]        r5_sq;
    logic                            r5_dotpos, r5_zd;
    logic signed [pvp_pkg::DW-1:0]   r5_dz;
    logic [pvp_pkg::VVW-1:0]         r5_vv;
    // Stage 6: magnitudes, signs and the view-cone flag.
    pvp_pkg::t_div_in                r6_out;

    // Combinational helpers.
    logic signed [pvp_pkg::VW-1:0]   n_v [3];
    logic signed [pvp_pkg::PW-1:0]   n_m [3][3];
    logic signed [pvp_pkg::PW-1:0]   n_t [3];
    logic signed [2*pvp_pkg::VW-1:0] n_sq [3];
    logic signed [pvp_pkg::CW_ENT-1:0] ent [3][3];
    logic [pvp_pkg::DW-1:0]          n_adot;
    logic [pvp_pkg::AHI-1:0]         n_ah;
    logic [pvp_pkg::ALO-1:0]         n_al;
    logic signed [pvp_pkg::NW-1:0]   n_d0e, n_d1e, n_dze, n_eye;

    // The whole pipeline advances together when the last stage can move.
    assign en      = !r_vld[NST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NST-1];
    assign o_data  = r6_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[NST-2:0], i_last};
        end
    end

    // Matrix entries, column 0 in the low bits of each row.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ent[r][c] = i_rot[r][16*c +: 16];
            end
        end
    end

    // Stage 1 next values.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v[i] = pvp_pkg::VW'(i_pt[i]) - pvp_pkg::VW'(i_cam[i]);
        end
    end

    // Stage 2 next values: matrix products, dot terms and squares.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_m[r][c] = pvp_pkg::PW'(ent[r][c]) * pvp_pkg::PW'(r1_v[c]);
            end
            n_t[r]  = pvp_pkg::PW'(ent[r][2]) * pvp_pkg::PW'(r1_v[r]);
            n_sq[r] = (2*pvp_pkg::VW)'(r1_v[r]) * (2*pvp_pkg::VW)'(r1_v[r]);
        end
    end

    // Stage 4 helpers.
    always_comb begin
        n_adot = r3_dot[pvp_pkg::DW-1] ? pvp_pkg::DW'(-r3_dot) : pvp_pkg::DW'(r3_dot);
        n_ah   = n_adot[pvp_pkg::DW-1:pvp_pkg::ALO];
        n_al   = n_adot[pvp_pkg::ALO-1:0];
        n_d0e  = pvp_pkg::NW'(r3_d[0]);
        n_d1e  = pvp_pkg::NW'(r3_d[1]);
        n_dze  = pvp_pkg::NW'(r3_d[2]);
        n_eye  = pvp_pkg::NW'(pvp_pkg::EYE_NEG);
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v <= n_v;

            r2_m <= n_m;
            r2_t <= n_t;
            for (int r = 0; r < 3; r++) begin
                r2_s[r] <= n_sq[r][pvp_pkg::SQW-1:0];
            end

            for (int r = 0; r < 3; r++) begin
                r3_d[r] <= pvp_pkg::DW'(r2_m[r][0]) + pvp_pkg::DW'(r2_m[r][1])
                         + pvp_pkg::DW'(r2_m[r][2]);
            end
            r3_dot <= pvp_pkg::DW'(r2_t[0]) + pvp_pkg::DW'(r2_t[1]) + pvp_pkg::DW'(r2_t[2]);
            r3_vv  <= pvp_pkg::VVW'(r2_s[0]) + pvp_pkg::VVW'(r2_s[1])
                    + pvp_pkg::VVW'(r2_s[2]);

            r4_px     <= n_d0e * n_eye;
            r4_py     <= n_d1e * n_eye;
            r4_hx     <= n_dze * pvp_pkg::NW'(HALF_X);
            r4_hy     <= n_dze * pvp_pkg::NW'(HALF_Y);
            r4_hh     <= n_ah * n_ah;
            r4_hl     <= n_ah * n_al;
            r4_ll     <= n_al * n_al;
            r4_dotpos <= (r3_dot > 0);
            r4_zd     <= (r3_d[2] == '0);
            r4_dz     <= r3_d[2];
            r4_vv     <= r3_vv;

            r5_nx     <= r4_px + r4_hx;
            r5_ny     <= r4_py + r4_hy;
            r5_sq     <= (pvp_pkg::SQ2W'(r4_hh) << (2*pvp_pkg::ALO))
                       + (pvp_pkg::SQ2W'(r4_hl) << (pvp_pkg::ALO + 1))
                       + pvp_pkg::SQ2W'(r4_ll);
            r5_dotpos <= r4_dotpos;
            r5_zd     <= r4_zd;
            r5_dz     <= r4_dz;
            r5_vv     <= r4_vv;

            // Hidden when facing away or outside the cone 2*dot^2 < |v|^2.
            r6_out.hidden     <= r5_dotpos || ({r5_sq, 1'b0} < {r5_vv, 28'd0});
            r6_out.nabs_x     <= r5_nx[pvp_pkg::NW-1] ? pvp_pkg::NMAG'(-r5_nx)
                                                      : pvp_pkg::NMAG'(r5_nx);
            r6_out.nabs_y     <= r5_ny[pvp_pkg::NW-1] ? pvp_pkg::NMAG'(-r5_ny)
                                                      : pvp_pkg::NMAG'(r5_ny);
            r6_out.neg_x      <= r5_nx[pvp_pkg::NW-1] ^ r5_dz[pvp_pkg::DW-1];
            r6_out.neg_y      <= r5_ny[pvp_pkg::NW-1] ^ r5_dz[pvp_pkg::DW-1];
            r6_out.dzabs      <= r5_dz[pvp_pkg::DW-1] ? pvp_pkg::DZM'(-r5_dz)
                                                      : pvp_pkg::DZM'(r5_dz);
            r6_out.zero_depth <= r5_zd;
            r6_out.last       <= r_last[NST-2];
        end
    end

endmodule

@@ sv/pvp_div.sv @@
module pvp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pvp_pkg::t_div_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pvp_pkg::t_result  o_res
);

    // Stage 0 checks for overflow, stages 1..QW each resolve one quotient bit.
    localparam int NS = pvp_pkg::QW + 1;

    logic                          en;
    logic [NS-1:0]                 r_vld;
    logic                          r_ovld;
    logic [pvp_pkg::NMAG-1:0]      r_rem [NS][2];
    logic [pvp_pkg::QW-1:0]        r_q   [NS][2];
    logic                          r_ov  [NS][2];
    logic                          r_neg [NS][2];
    logic [pvp_pkg::DZM-1:0]       r_dz  [NS];
    logic                          r_hid [NS];
    logic                          r_zd  [NS];
    logic                          r_lst [NS];
    pvp_pkg::t_result              r_res;

    logic [pvp_pkg::NMAG-1:0]      n_rem [NS][2];
    logic [pvp_pkg::QW-1:0]        n_q   [NS][2];
    logic [pvp_pkg::CMPW-1:0]      n_sub [NS];
    logic [pvp_pkg::NMAG-1:0]      n_in  [2];
    logic                          n_neg [2];
    logic [pvp_pkg::QW-1:0]        n_scr [2];
    logic [pvp_pkg::QW-1:0]        q_lim;

    assign en      = !r_ovld || i_ready;
    assign o_ready = en;
    assign o_valid = r_ovld;
    assign o_res   = r_res;
    assign n_in[0]  = i_data.nabs_x;
    assign n_in[1]  = i_data.nabs_y;
    assign n_neg[0] = i_data.neg_x;
    assign n_neg[1] = i_data.neg_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[NS-2:0], i_valid};
            r_ovld <= r_vld[NS-1];
        end
    end

    // Restoring division: one compare and subtract per stage and lane.
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_sub[s] = pvp_pkg::CMPW'(r_dz[s]) << (pvp_pkg::QW - 1 - s);
            for (int l = 0; l < 2; l++) begin
                n_rem[s][l] = r_rem[s][l];
                n_q[s][l]   = r_q[s][l];
                if (s < NS - 1 && pvp_pkg::CMPW'(r_rem[s][l]) >= n_sub[s]) begin
                    n_rem[s][l] = r_rem[s][l] - pvp_pkg::NMAG'(n_sub[s]);
                    n_q[s][l]   = r_q[s][l]
                                | (pvp_pkg::QW'(1) << (pvp_pkg::QW - 1 - s));
                end
            end
        end
    end

    // Saturate to 16 bits signed, truncating toward zero; zero depth gives 0.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q_lim = r_q[NS-1][l];
            if (r_neg[NS-1][l]) begin
                if (r_ov[NS-1][l] || q_lim > 16'd32768) begin
                    n_scr[l] = 16'h8000;
                end else begin
                    n_scr[l] = 16'd0 - q_lim;
                end
            end else begin
                if (r_ov[NS-1][l] || q_lim > 16'd32767) begin
                    n_scr[l] = 16'h7FFF;
                end else begin
                    n_scr[l] = q_lim;
                end
            end
            if (r_zd[NS-1]) begin
                n_scr[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Entry stage: quotient of 2^16 or more saturates either way.
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= n_in[l];
                r_q[0][l]   <= '0;
                r_ov[0][l]  <= pvp_pkg::CMPW'(n_in[l])
                               >= (pvp_pkg::CMPW'(i_data.dzabs) << pvp_pkg::QW);
                r_neg[0][l] <= n_neg[l];
            end
            r_dz[0]  <= i_data.dzabs;
            r_hid[0] <= i_data.hidden;
            r_zd[0]  <= i_data.zero_depth;
            r_lst[0] <= i_data.last;

            for (int s = 1; s < NS; s++) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s-1][l];
                    r_q[s][l]   <= n_q[s-1][l];
                    r_ov[s][l]  <= r_ov[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                end
                r_dz[s]  <= r_dz[s-1];
                r_hid[s] <= r_hid[s-1];
                r_zd[s]  <= r_zd[s-1];
                r_lst[s] <= r_lst[s-1];
            end

            r_res.screen_x   <= n_scr[0];
            r_res.screen_y   <= n_scr[1];
            r_res.hidden     <= r_hid[NS-1];
            r_res.zero_depth <= r_zd[NS-1];
            r_res.last_out   <= r_lst[NS-1];
        end
    end

endmodule

@@ sv/perspective_vertex_project_unit.sv @@
// Channel   Direction  Transaction contents
// i_vtx     in         point_x, point_y, point_z (Q16.8), last_point
// o_pix     out        screen_x, screen_y, hidden, zero_depth, last_out
// i_cfg_*   in         register index and write data, no handshake
//
// One vertex transaction is accepted per cycle unless stalled; results pass
// through six arithmetic stages, the seventeen-stage restoring divider (one
// quotient bit per stage) and the output register. Synchronous active-low reset
// clears the pipeline valid bits and loads camera and rotation defaults. An
// o_pix stall holds the divider, and the front end once its output is valid.
module perspective_vertex_project_unit #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pvp_vtx_if.sink                            i_vtx,
    pvp_pix_if.source                          o_pix,
    input  logic                               i_cfg_we,
    input  logic [pvp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pvp_pkg::CW_ROW-1:0]         i_cfg_data
);

    logic signed [pvp_pkg::CW_COORD-1:0] r_cam [3];
    logic [pvp_pkg::CW_ROW-1:0]          r_rot [3];
    logic signed [pvp_pkg::CW_COORD-1:0] pt [3];
    logic                                f_valid, f_ready;
    pvp_pkg::t_div_in                    f_data;
    pvp_pkg::t_result                    res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= pvp_pkg::RST_CAM_X;
            r_cam[1] <= pvp_pkg::RST_CAM_Y;
            r_cam[2] <= pvp_pkg::RST_CAM_Z;
            r_rot[0] <= pvp_pkg::RST_ROW0;
            r_rot[1] <= pvp_pkg::RST_ROW1;
            r_rot[2] <= pvp_pkg::RST_ROW2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pvp_pkg::CFG_CAM_X:    r_cam[0] <= i_cfg_data[pvp_pkg::CW_COORD-1:0];
                pvp_pkg::CFG_CAM_Y:    r_cam[1] <= i_cfg_data[pvp_pkg::CW_COORD-1:0];
                pvp_pkg::CFG_CAM_Z:    r_cam[2] <= i_cfg_data[pvp_pkg::CW_COORD-1:0];
                pvp_pkg::CFG_ROT_ROW0: r_rot[0] <= i_cfg_data;
                pvp_pkg::CFG_ROT_ROW1: r_rot[1] <= i_cfg_data;
                pvp_pkg::CFG_ROT_ROW2: r_rot[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pt[0] = i_vtx.point_x;
    assign pt[1] = i_vtx.point_y;
    assign pt[2] = i_vtx.point_z;

    // Offset, rotation, numerators and the view-cone test.
    pvp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (i_vtx.ready),
        .i_pt    (pt),
        .i_last  (i_vtx.last_point),
        .i_cam   (r_cam),
        .i_rot   (r_rot),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    // Perspective divide and saturation.
    pvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (o_pix.valid),
        .i_ready (o_pix.ready),
        .o_res   (res)
    );

    assign o_pix.screen_x   = res.screen_x;
    assign o_pix.screen_y   = res.screen_y;
    assign o_pix.hidden     = res.hidden;
    assign o_pix.zero_depth = res.zero_depth;
    assign o_pix.last_out   = res.last_out;

endmodule
